/* hdl/sod_pkg.sv */
// Shared types, constants and register codes for the sonar drive core.
package sod_pkg;

  // Frame length default and queue depth
  localparam int unsigned FRAME_LENGTH_DEF = 17;
  localparam int unsigned QUEUE_DEPTH      = 2;

  // Configuration register indexes
  localparam logic [2:0] CFG_NEAR_TH   = 3'd0;
  localparam logic [2:0] CFG_SIDE_TH   = 3'd1;
  localparam logic [2:0] CFG_SLOW_DUTY = 3'd2;
  localparam logic [2:0] CFG_SPIN_DUTY = 3'd3;
  localparam logic [2:0] CFG_VEER_DUTY = 3'd4;

  // Configuration reset values
  localparam logic [7:0] NEAR_TH_RST   = 8'h14;
  localparam logic [7:0] SIDE_TH_RST   = 8'h19;
  localparam logic [7:0] SLOW_DUTY_RST = 8'd50;
  localparam logic [7:0] SPIN_DUTY_RST = 8'd200;
  localparam logic [7:0] VEER_DUTY_RST = 8'd255;

  // Drive modes
  localparam logic [1:0] MODE_NORMAL     = 2'd0;
  localparam logic [1:0] MODE_RIGHT_SPIN = 2'd1;
  localparam logic [1:0] MODE_LEFT_SPIN  = 2'd2;

  // Direction pin masks: bit0 LA, bit1 LB, bit2 RA, bit3 RB
  localparam logic [3:0] PIN_NONE = 4'b0000;
  localparam logic [3:0] PIN_LA   = 4'b0001;
  localparam logic [3:0] PIN_LB   = 4'b0010;
  localparam logic [3:0] PIN_RA   = 4'b0100;
  localparam logic [3:0] PIN_RB   = 4'b1000;

  // Frame byte positions the rules read
  localparam int unsigned POS_B5  = 5;
  localparam int unsigned POS_B6  = 6;
  localparam int unsigned POS_B7  = 7;
  localparam int unsigned POS_B8  = 8;
  localparam int unsigned POS_B9  = 9;
  localparam int unsigned POS_B12 = 12;
  localparam int unsigned POS_B14 = 14;

  // Bytes of one finished frame that the rules need
  typedef struct packed {
    logic [7:0] b5;
    logic [7:0] b6;
    logic [7:0] b7;
    logic [7:0] b8;
    logic [7:0] b9;
    logic [7:0] b12;
    logic [7:0] b14;
  } sod_frame_t;

  // Configuration register set
  typedef struct packed {
    logic [7:0] near_th;
    logic [7:0] side_th;
    logic [7:0] slow_duty;
    logic [7:0] spin_duty;
    logic [7:0] veer_duty;
  } sod_cfg_t;

  // Held drive state, emitted once per frame
  typedef struct packed {
    logic [7:0] duty_l;
    logic [7:0] duty_r;
    logic [3:0] pins;
    logic [1:0] enables;
    logic       warning;
    logic [1:0] mode;
  } sod_drive_t;

endpackage

/* hdl/sod_front.sv */
// Front end: counts bytes into frames and captures the bytes the rules use.
module sod_front #(
  parameter int unsigned FRAME_LENGTH = sod_pkg::FRAME_LENGTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               q_full_i,
  output logic               push_o,
  output sod_pkg::sod_frame_t frame_o
);

  localparam int unsigned PosW = $clog2(FRAME_LENGTH);
  localparam logic [PosW-1:0] PosLast = PosW'(FRAME_LENGTH - 1);
  localparam logic [PosW-1:0] P5  = PosW'(sod_pkg::POS_B5);
  localparam logic [PosW-1:0] P6  = PosW'(sod_pkg::POS_B6);
  localparam logic [PosW-1:0] P7  = PosW'(sod_pkg::POS_B7);
  localparam logic [PosW-1:0] P8  = PosW'(sod_pkg::POS_B8);
  localparam logic [PosW-1:0] P9  = PosW'(sod_pkg::POS_B9);
  localparam logic [PosW-1:0] P12 = PosW'(sod_pkg::POS_B12);
  localparam logic [PosW-1:0] P14 = PosW'(sod_pkg::POS_B14);

  logic [PosW-1:0]     pos_q, pos_d;
  sod_pkg::sod_frame_t cap_q, cap_d;
  logic                accept;
  logic                last;

  assign last       = (pos_q == PosLast);
  // only the frame's last word needs room in the queue
  assign in_ready_o = !q_full_i || !last;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && last;

  // capture slots, with the incoming word forwarded at its own position
  always_comb begin
    cap_d = cap_q;
    if (accept) begin
      if (pos_q == P5)  cap_d.b5  = rx_byte_i;
      if (pos_q == P6)  cap_d.b6  = rx_byte_i;
      if (pos_q == P7)  cap_d.b7  = rx_byte_i;
      if (pos_q == P8)  cap_d.b8  = rx_byte_i;
      if (pos_q == P9)  cap_d.b9  = rx_byte_i;
      if (pos_q == P12) cap_d.b12 = rx_byte_i;
      if (pos_q == P14) cap_d.b14 = rx_byte_i;
    end
  end

  assign frame_o = cap_d;

  // byte position counter
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = last ? '0 : pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_q <= cap_d;
  end

endmodule

/* hdl/sod_queue.sv */
// Short frame queue between the front end and the rule engine.
module sod_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sod_pkg::sod_frame_t data_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                pop_i,
  output sod_pkg::sod_frame_t data_o
);

  localparam int unsigned Depth = sod_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  sod_pkg::sod_frame_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hdl/sod_back.sv */
// Rule engine: applies the threshold rules per frame and holds the drive state.
module sod_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sod_pkg::sod_cfg_t   cfg_i,
  input  logic                q_valid_i,
  output logic                pop_o,
  input  sod_pkg::sod_frame_t frame_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sod_pkg::sod_drive_t drive_o
);

  sod_pkg::sod_drive_t st_q, st_d;
  logic                out_valid_q, out_valid_d;
  logic                run_r3, run_r45, r3_hit;
  logic                n5, n7, n9, n12, n14;
  logic                s5, s6, s8, s9;

  assign pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  // near and side compares
  assign n5  = frame_i.b5  <= cfg_i.near_th;
  assign n7  = frame_i.b7  <= cfg_i.near_th;
  assign n9  = frame_i.b9  <= cfg_i.near_th;
  assign n12 = frame_i.b12 <= cfg_i.near_th;
  assign n14 = frame_i.b14 <= cfg_i.near_th;
  assign s5  = frame_i.b5  <= cfg_i.side_th;
  assign s6  = frame_i.b6  <= cfg_i.side_th;
  assign s8  = frame_i.b8  <= cfg_i.side_th;
  assign s9  = frame_i.b9  <= cfg_i.side_th;

  // frame rules in order
  always_comb begin
    st_d    = st_q;
    run_r3  = 1'b0;
    run_r45 = 1'b0;
    r3_hit  = 1'b0;
    unique case (st_q.mode)
      sod_pkg::MODE_RIGHT_SPIN: begin
        st_d.duty_l = cfg_i.spin_duty;
        st_d.duty_r = cfg_i.spin_duty;
        st_d.pins   = sod_pkg::PIN_LA | sod_pkg::PIN_RA;
        if (!n5) begin
          st_d.pins = sod_pkg::PIN_NONE;
          st_d.mode = sod_pkg::MODE_NORMAL;
          run_r3    = 1'b1;
          run_r45   = 1'b1;
        end
      end
      sod_pkg::MODE_LEFT_SPIN: begin
        st_d.duty_l = cfg_i.spin_duty;
        st_d.duty_r = cfg_i.spin_duty;
        st_d.pins   = sod_pkg::PIN_LB | sod_pkg::PIN_RB;
        if (!n9) begin
          st_d.pins = sod_pkg::PIN_NONE;
          st_d.mode = sod_pkg::MODE_NORMAL;
          run_r45   = 1'b1;
        end
      end
      default: begin
        // normal (unused code treated alike)
        st_d.mode = sod_pkg::MODE_NORMAL;
        if (n12 || n14) begin
          st_d.warning = 1'b1;
          st_d.duty_l  = cfg_i.slow_duty;
          st_d.duty_r  = cfg_i.slow_duty;
          st_d.pins    = sod_pkg::PIN_LA | sod_pkg::PIN_RB;
          st_d.enables = 2'b11;
        end else begin
          st_d.warning = 1'b0;
          st_d.pins    = sod_pkg::PIN_NONE;
        end
        if (n5 && n7) begin
          st_d.duty_l = '0;
          st_d.duty_r = '0;
          st_d.pins   = sod_pkg::PIN_NONE;
          st_d.mode   = sod_pkg::MODE_RIGHT_SPIN;
        end else begin
          run_r3  = 1'b1;
          run_r45 = 1'b1;
        end
      end
    endcase

    // left spin entry
    if (run_r3 && n9 && n7) begin
      r3_hit      = 1'b1;
      st_d.duty_l = '0;
      st_d.duty_r = '0;
      st_d.pins   = sod_pkg::PIN_NONE;
      st_d.mode   = sod_pkg::MODE_LEFT_SPIN;
    end

    // side veers
    if (run_r45 && !r3_hit) begin
      if (s5 || s6) begin
        st_d.duty_l     = cfg_i.veer_duty;
        st_d.duty_r     = cfg_i.veer_duty;
        st_d.pins       = sod_pkg::PIN_LA;
        st_d.enables[0] = 1'b1;
      end
      if (s8 || s9) begin
        st_d.duty_l     = cfg_i.veer_duty;
        st_d.duty_r     = cfg_i.veer_duty;
        st_d.pins       = sod_pkg::PIN_RB;
        st_d.enables[1] = 1'b1;
      end
    end
  end

  // result word handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        st_q <= st_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = st_q;

endmodule

/* hdl/sonar_obstacle_avoidance_drive_core.sv */
// Top level: sonar frame counter, frame queue and motor drive rule engine.
// One sensor word per cycle while in_ready_o is high; frames are FRAME_LENGTH words.
// A drive word is valid after the last word of its frame is taken, once the frame
// has passed the frame queue storage and then the rule engine state register.
// The two-entry queue absorbs output stalls.
// Reset clears the counter, queue, drive state and loads the default thresholds and duties.
module sonar_obstacle_avoidance_drive_core #(
  parameter int unsigned FRAME_LENGTH = sod_pkg::FRAME_LENGTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] left_duty_o,
  output logic [7:0] right_duty_o,
  output logic       left_pin_a_o,
  output logic       left_pin_b_o,
  output logic       right_pin_a_o,
  output logic       right_pin_b_o,
  output logic       left_enable_o,
  output logic       right_enable_o,
  output logic       rear_warning_o,
  output logic [1:0] drive_mode_o
);

  sod_pkg::sod_cfg_t   cfg_q;
  sod_pkg::sod_frame_t push_frame, pop_frame;
  sod_pkg::sod_drive_t drive;
  logic                push, q_full, q_valid, pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_th   <= sod_pkg::NEAR_TH_RST;
      cfg_q.side_th   <= sod_pkg::SIDE_TH_RST;
      cfg_q.slow_duty <= sod_pkg::SLOW_DUTY_RST;
      cfg_q.spin_duty <= sod_pkg::SPIN_DUTY_RST;
      cfg_q.veer_duty <= sod_pkg::VEER_DUTY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sod_pkg::CFG_NEAR_TH:   cfg_q.near_th   <= cfg_data_i;
        sod_pkg::CFG_SIDE_TH:   cfg_q.side_th   <= cfg_data_i;
        sod_pkg::CFG_SLOW_DUTY: cfg_q.slow_duty <= cfg_data_i;
        sod_pkg::CFG_SPIN_DUTY: cfg_q.spin_duty <= cfg_data_i;
        sod_pkg::CFG_VEER_DUTY: cfg_q.veer_duty <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sod_front #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .frame_o    (push_frame)
  );

  sod_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_frame),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (pop_frame)
  );

  sod_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .pop_o       (pop),
    .frame_i     (pop_frame),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_o     (drive)
  );

  // drive word fields
  assign left_duty_o    = drive.duty_l;
  assign right_duty_o   = drive.duty_r;
  assign left_pin_a_o   = drive.pins[0];
  assign left_pin_b_o   = drive.pins[1];
  assign right_pin_a_o  = drive.pins[2];
  assign right_pin_b_o  = drive.pins[3];
  assign left_enable_o  = drive.enables[0];
  assign right_enable_o = drive.enables[1];
  assign rear_warning_o = drive.warning;
  assign drive_mode_o   = drive.mode;

endmodule
